[rtl/bpps_pkg.sv]
// shared types, register map, color table and pixel helpers for the bitplane shifter
`timescale 1ns / 1ps
package bpps_pkg;

    localparam int PALETTE_SIZE     = 16;
    localparam int PIXELS_PER_CHUNK = 16;
    localparam int IDX_W            = $clog2(PALETTE_SIZE);
    localparam int CNT_W            = $clog2(PIXELS_PER_CHUNK);
    localparam int NUM_PLANES       = 4;
    localparam int PLANE_W          = 16;

    // item actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CHUNK = 2'd2;

    // resolution codes
    localparam logic [1:0] RES_LOW  = 2'd0;
    localparam logic [1:0] RES_MED  = 2'd1;
    localparam logic [1:0] RES_HIGH = 2'd2;
    localparam logic [1:0] RES_OFF  = 2'd3;

    // register byte offsets
    localparam logic [7:0] OFF_BASE_HIGH = 8'h01;
    localparam logic [7:0] OFF_BASE_MID  = 8'h03;
    localparam logic [7:0] OFF_SYNC      = 8'h0A;
    localparam logic [7:0] OFF_BASE_LOW  = 8'h0D;
    localparam logic [7:0] OFF_RES       = 8'h60;
    localparam logic [7:0] OFF_PAL_LO    = 8'h40;
    localparam logic [7:0] OFF_PAL_HI    = 8'h5F;

    localparam logic [7:0] BASE_HIGH_RESET = 8'hF8;

    typedef logic [15:0] t_color;

    typedef struct packed {
        logic [1:0]             action;
        logic [7:0]             offset;
        logic [7:0]             write_data;
        logic [NUM_PLANES-1:0][PLANE_W-1:0] planes;
    } t_item;

    typedef struct packed {
        logic [1:0]  resolution;
        logic        enabled;
        logic [23:0] video_base;
    } t_shift_state;

    function automatic t_color reset_color(input logic [IDX_W-1:0] idx);
        t_color c;
        case (idx)
            4'd0:    c = 16'h0FFF;
            4'd1:    c = 16'h0F00;
            4'd2:    c = 16'h00F0;
            4'd3:    c = 16'h0FF0;
            4'd4:    c = 16'h000F;
            4'd5:    c = 16'h0F0F;
            4'd6:    c = 16'h00FF;
            4'd7:    c = 16'h0555;
            4'd8:    c = 16'h0333;
            4'd9:    c = 16'h0F33;
            4'd10:   c = 16'h03F3;
            4'd11:   c = 16'h0FF3;
            4'd12:   c = 16'h033F;
            4'd13:   c = 16'h0F3F;
            4'd14:   c = 16'h03FF;
            default: c = 16'h0000;
        endcase
        return c;
    endfunction

    // abc -> abcabcab
    function automatic logic [7:0] widen3(input logic [2:0] c);
        return {c, c, c[2:1]};
    endfunction

    function automatic logic [IDX_W-1:0] plane_index(input logic [1:0] res,
                                                     input logic [NUM_PLANES-1:0] bits);
        logic [IDX_W-1:0] idx;
        case (res)
            RES_LOW:  idx = bits;
            RES_MED:  idx = {2'b00, bits[1:0]};
            default:  idx = {3'b000, bits[0]};
        endcase
        return idx;
    endfunction

    function automatic logic [2:0] horiz_rep(input logic [1:0] res);
        return (res == RES_LOW) ? 3'd4 : 3'd2;
    endfunction

    function automatic logic [1:0] vert_rep(input logic [1:0] res);
        return (res == RES_HIGH) ? 2'd1 : 2'd3;
    endfunction

endpackage

[rtl/bpps_regs.sv]
// register file: base bytes, sync, resolution and the color table with byte access
`timescale 1ns / 1ps
module bpps_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [7:0]                 i_offset,
    input  logic [7:0]                 i_write_data,
    input  logic                       i_pix_sel,
    input  logic [bpps_pkg::IDX_W-1:0] i_pix_idx,
    output logic [7:0]                 o_read_byte,
    output bpps_pkg::t_color           o_color,
    output bpps_pkg::t_shift_state     o_state
);
    import bpps_pkg::*;

    logic [7:0]  r_base_high;
    logic [7:0]  r_base_mid;
    logic [7:0]  r_base_low;
    logic [7:0]  r_sync;
    logic [1:0]  r_res;
    logic        r_enabled;
    t_color      r_pal [PALETTE_SIZE];

    logic             pal_hit;
    logic [IDX_W-1:0] pal_wr_idx;
    logic [IDX_W-1:0] rd_idx;

    assign pal_hit    = i_offset inside {[OFF_PAL_LO:OFF_PAL_HI]};
    assign pal_wr_idx = i_offset[IDX_W:1];
    assign rd_idx     = i_pix_sel ? i_pix_idx : pal_wr_idx;
    assign o_color    = r_pal[rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_high <= BASE_HIGH_RESET;
            r_base_mid  <= '0;
            r_base_low  <= '0;
            r_sync      <= '0;
            r_res       <= RES_LOW;
            r_enabled   <= 1'b0;
            for (int i = 0; i < PALETTE_SIZE; i++) begin
                r_pal[i] <= reset_color(IDX_W'(i));
            end
        end else if (i_wr_en) begin
            case (i_offset)
                OFF_BASE_HIGH: r_base_high <= i_write_data;
                OFF_BASE_MID:  r_base_mid  <= i_write_data;
                OFF_SYNC:      r_sync      <= i_write_data;
                OFF_BASE_LOW:  r_base_low  <= i_write_data;
                OFF_RES: begin
                    r_res     <= i_write_data[1:0];
                    r_enabled <= 1'b1;
                end
                default: begin
                    if (pal_hit) begin
                        if (i_offset[0]) begin
                            r_pal[pal_wr_idx][7:0] <= i_write_data;
                        end else begin
                            r_pal[pal_wr_idx][15:8] <= i_write_data;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        case (i_offset)
            OFF_BASE_HIGH: o_read_byte = r_base_high;
            OFF_BASE_MID:  o_read_byte = r_base_mid;
            OFF_SYNC:      o_read_byte = r_sync;
            OFF_BASE_LOW:  o_read_byte = r_base_low;
            OFF_RES:       o_read_byte = {6'b000000, r_res};
            default: begin
                if (pal_hit) begin
                    o_read_byte = i_offset[0] ? o_color[7:0] : o_color[15:8];
                end else begin
                    o_read_byte = '0;
                end
            end
        endcase
    end

    assign o_state.resolution = r_res;
    assign o_state.enabled    = r_enabled;
    assign o_state.video_base = {r_base_high, r_base_mid, r_base_low};

endmodule

[rtl/bpps_emit.sv]
// pixel emitter: plane shift registers, pixel counter and the result register
`timescale 1ns / 1ps
module bpps_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_item_valid,
    input  bpps_pkg::t_item            i_item,
    input  logic                       i_ready,
    input  bpps_pkg::t_shift_state     i_state,
    input  bpps_pkg::t_color           i_color,
    input  logic [7:0]                 i_read_byte,
    output logic                       o_item_take,
    output logic                       o_wr_en,
    output logic                       o_pix_sel,
    output logic [bpps_pkg::IDX_W-1:0] o_pix_idx,
    output logic                       o_valid,
    output logic                       o_kind,
    output logic [7:0]                 o_read_data,
    output logic [3:0]                 o_color_index,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic [2:0]                 o_horiz_repeat,
    output logic [1:0]                 o_vert_repeat,
    output logic [23:0]                o_video_base,
    output logic                       o_last
);
    import bpps_pkg::*;

    logic                                r_busy;
    logic [CNT_W-1:0]                    r_cnt;
    logic [NUM_PLANES-1:0][PLANE_W-1:0]  r_planes;
    logic                                r_valid;

    logic                                out_free;
    logic                                start_chunk;
    logic                                is_read;
    logic                                emit_pix;
    logic [NUM_PLANES-1:0]               pix_bits;
    logic [CNT_W-1:0]                    cur_cnt;
    logic [NUM_PLANES-1:0][PLANE_W-1:0]  cur_planes;

    assign out_free    = !r_valid || i_ready;
    assign o_item_take = out_free && !r_busy && i_item_valid;
    assign o_wr_en     = o_item_take && (i_item.action == ACT_WRITE);
    assign is_read     = o_item_take && (i_item.action == ACT_READ);
    assign start_chunk = o_item_take && (i_item.action == ACT_CHUNK)
                         && i_state.enabled && (i_state.resolution != RES_OFF);
    assign emit_pix    = out_free && (r_busy || start_chunk);

    // first pixel of a chunk comes straight from the incoming word
    assign cur_planes = r_busy ? r_planes : i_item.planes;
    assign cur_cnt    = r_busy ? r_cnt : '0;

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            pix_bits[p] = cur_planes[p][PLANE_W-1];
        end
    end

    assign o_pix_idx = plane_index(i_state.resolution, pix_bits);
    assign o_pix_sel = r_busy || (i_item.action != ACT_READ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= emit_pix || is_read;
            if (emit_pix) begin
                r_cnt <= cur_cnt + 1'b1;
                r_busy <= (cur_cnt != CNT_W'(PIXELS_PER_CHUNK - 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_pix) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_planes[p] <= {cur_planes[p][PLANE_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            o_kind       <= emit_pix;
            o_video_base <= i_state.video_base;
            if (emit_pix) begin
                o_read_data    <= '0;
                o_color_index  <= o_pix_idx;
                o_red          <= widen3(i_color[10:8]);
                o_green        <= widen3(i_color[6:4]);
                o_blue         <= widen3(i_color[2:0]);
                o_horiz_repeat <= horiz_rep(i_state.resolution);
                o_vert_repeat  <= vert_rep(i_state.resolution);
                o_last         <= (cur_cnt == CNT_W'(PIXELS_PER_CHUNK - 1));
            end else begin
                o_read_data    <= i_read_byte;
                o_color_index  <= '0;
                o_red          <= '0;
                o_green        <= '0;
                o_blue         <= '0;
                o_horiz_repeat <= '0;
                o_vert_repeat  <= '0;
                o_last         <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;

endmodule

[rtl/bitplane_palette_shifter_unit.sv]
// top level of the bitplane shifter: input word register, register file and pixel emitter
`timescale 1ns / 1ps
// Takes one word per handshake: a register byte write, a register byte read or a
// 16-pixel bitplane chunk. A write gives no result, a read gives one result,
// registered in the cycle after it leaves the input register, and a chunk gives 16
// pixel results, leftmost first, one per cycle while i_ready is high; the pixel counter
// in the emitter counts those 16 pixels. A chunk taken before the resolution register is
// written, or with resolution off, gives no result. One word waits in the input
// register while the emitter is busy, and the result register lets the next result be
// built as soon as the current one is taken. Register changes take effect in word order,
// so a chunk always sees the palette, resolution and base as left by the words before it.
module bitplane_palette_shifter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_offset,
    input  logic [7:0]  i_write_data,
    input  logic [15:0] i_plane_zero,
    input  logic [15:0] i_plane_one,
    input  logic [15:0] i_plane_two,
    input  logic [15:0] i_plane_three,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_read_data,
    output logic [3:0]  o_color_index,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [2:0]  o_horiz_repeat,
    output logic [1:0]  o_vert_repeat,
    output logic [23:0] o_video_base,
    output logic        o_last
);
    import bpps_pkg::*;

    logic          r_item_valid;
    t_item         r_item;
    logic          item_take;
    logic          wr_en;
    logic          pix_sel;
    logic [IDX_W-1:0] pix_idx;
    logic [7:0]    read_byte;
    t_color        color;
    t_shift_state  state;

    assign o_ready = !r_item_valid || item_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_item_valid <= 1'b1;
        end else if (item_take) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.action     <= i_action;
            r_item.offset     <= i_offset;
            r_item.write_data <= i_write_data;
            r_item.planes     <= {i_plane_three, i_plane_two, i_plane_one, i_plane_zero};
        end
    end

    bpps_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_offset     (r_item.offset),
        .i_write_data (r_item.write_data),
        .i_pix_sel    (pix_sel),
        .i_pix_idx    (pix_idx),
        .o_read_byte  (read_byte),
        .o_color      (color),
        .o_state      (state)
    );

    bpps_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (r_item_valid),
        .i_item         (r_item),
        .i_ready        (i_ready),
        .i_state        (state),
        .i_color        (color),
        .i_read_byte    (read_byte),
        .o_item_take    (item_take),
        .o_wr_en        (wr_en),
        .o_pix_sel      (pix_sel),
        .o_pix_idx      (pix_idx),
        .o_valid        (o_valid),
        .o_kind         (o_kind),
        .o_read_data    (o_read_data),
        .o_color_index  (o_color_index),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_horiz_repeat (o_horiz_repeat),
        .o_vert_repeat  (o_vert_repeat),
        .o_video_base   (o_video_base),
        .o_last         (o_last)
    );

endmodule

[rtl/bpps_checker.sv]
// port-level checker for the bitplane shifter and its bind to the top level
`timescale 1ns / 1ps
module bpps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_kind,
    input logic [3:0]  o_color_index,
    input logic [2:0]  o_horiz_repeat,
    input logic [1:0]  o_vert_repeat,
    input logic [23:0] o_video_base,
    input logic        o_last
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_last)
            && $stable(o_color_index))
        else $error("result word changed while stalled");

    // a read result is a single word with no pixel fields
    a_read_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_kind |-> o_last && o_color_index == 4'd0 && o_horiz_repeat == 3'd0)
        else $error("read result malformed");

    a_repeat_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> (o_horiz_repeat == 3'd4 && o_vert_repeat == 2'd3)
            || (o_horiz_repeat == 3'd2 && o_vert_repeat == 2'd3)
            || (o_horiz_repeat == 3'd2 && o_vert_repeat == 2'd1))
        else $error("repeat counts do not match any resolution");

    // pixels of a chunk follow one another without gaps
    a_chunk_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_kind && !o_last |=> o_valid && o_kind)
        else $error("chunk interrupted");

    // no register write can land inside a chunk
    a_chunk_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_kind && !o_last |=> $stable(o_video_base)
            && $stable(o_horiz_repeat))
        else $error("chunk state changed mid-chunk");

endmodule

bind bitplane_palette_shifter_unit bpps_checker u_bpps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_kind         (o_kind),
    .o_color_index  (o_color_index),
    .o_horiz_repeat (o_horiz_repeat),
    .o_vert_repeat  (o_vert_repeat),
    .o_video_base   (o_video_base),
    .o_last         (o_last)
);
